// ===== rtl/lcts_pkg.sv =====
// shared types and constants for the load cell tare, watchdog and scaler block
package lcts_pkg;

    localparam int WEIGHT_BITS = 48;
    localparam int TIME_BITS   = 32;
    localparam int COUNT_BITS  = 32;
    localparam int DIVISOR_BITS = 32;
    localparam int TARE_SUM_BITS = 32;
    localparam int TARE_CNT_BITS = 8;
    localparam int TIMEOUT_BITS = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // shared divider: quotient bits per pass and remainder width
    localparam int DIV_QBITS = WEIGHT_BITS;
    localparam int DIV_RBITS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_QBITS + 1);
    localparam int TARE_QBITS = TARE_SUM_BITS;

    // divisor magnitudes below this are replaced by 1.0
    localparam logic signed [DIVISOR_BITS-1:0] DIVISOR_MIN_MAG = 32'sd7;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR = 2'd2;

    localparam logic [2:0] KIND_BEGIN  = 3'd0;
    localparam logic [2:0] KIND_SAMPLE = 3'd1;
    localparam logic [2:0] KIND_POLL   = 3'd2;
    localparam logic [2:0] KIND_TARE   = 3'd3;
    localparam logic [2:0] KIND_OFFSET = 3'd4;

    localparam logic [2:0] STAT_OFFLINE = 3'd0;
    localparam logic [2:0] STAT_INIT    = 3'd1;
    localparam logic [2:0] STAT_HEALTHY = 3'd2;
    localparam logic [2:0] STAT_STALE   = 3'd3;
    localparam logic [2:0] STAT_FAULT   = 3'd4;

    localparam logic [1:0] TARE_IDLE    = 2'd0;
    localparam logic [1:0] TARE_COLLECT = 2'd1;
    localparam logic [1:0] TARE_DONE    = 2'd2;
    localparam logic [1:0] TARE_FAILED  = 2'd3;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_EXEC,
        SEQ_TARE_DIV,
        SEQ_TARE_FIN,
        SEQ_W_PREP,
        SEQ_W_DIV,
        SEQ_W_FIN,
        SEQ_REPORT
    } seq_state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] iters;
    } div_ctrl_t;

endpackage

// ===== rtl/lcts_div.sv =====
// shared restoring divider, one quotient bit per cycle
module lcts_div import lcts_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  div_ctrl_t            ctrl,
    input  logic [DIV_RBITS-1:0] init_rem,
    input  logic [DIV_QBITS-1:0] dividend,
    input  logic [DIV_RBITS-1:0] divisor,
    output logic                 busy,
    output logic [DIV_QBITS-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_RBITS-1:0] rem_reg, rem_next;
    logic [DIV_QBITS-1:0] sh_reg, sh_next;
    logic [DIV_QBITS-1:0] quo_reg, quo_next;
    logic [DIV_RBITS-1:0] dsr_reg, dsr_next;
    logic [DIV_RBITS:0]   trial;
    logic                 ge;

    assign trial = {rem_reg, sh_reg[DIV_QBITS-1]};
    assign ge    = trial >= {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (ctrl.start) begin
            busy_next = 1'b1;
            cnt_next  = ctrl.iters;
            rem_next  = init_rem;
            sh_next   = dividend;
            quo_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            rem_next = ge ? DIV_RBITS'(trial - {1'b0, dsr_reg}) : trial[DIV_RBITS-1:0];
            sh_next  = {sh_reg[DIV_QBITS-2:0], 1'b0};
            quo_next = {quo_reg[DIV_QBITS-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/load_cell_tare_watchdog_scaler.sv =====
// load cell tare, watchdog and weight scaler, top level
//
// One transaction at a time: s_ready is high only while the sequencer is idle. A begin, poll,
// tare request or offset load goes through the exec state to the report state. A sample
// also passes the weight prepare, divide and finish states: its time is set by one pass of
// the shared bit-serial divider for the weight quotient. When the quotient is sure to
// saturate, that pass is skipped. A sample that completes a tare average first runs a pass
// of the same divider for the new offset. The result register holds one finished result.
// The sequencer waits for it to drain before loading the next, so a stalled result holds
// the sequencer in its report state.
module load_cell_tare_watchdog_scaler import lcts_pkg::*; #(
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [2:0]                    s_kind,
    input  logic [TIME_BITS-1:0]          s_now_ms,
    input  logic signed [SAMPLE_BITS-1:0] s_raw_sample,
    input  logic [TARE_CNT_BITS-1:0]      s_tare_count,
    input  logic signed [SAMPLE_BITS-1:0] s_offset_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_sensor_status,
    output logic [1:0]                    m_tare_phase,
    output logic                          m_tare_accepted,
    output logic                          m_has_reading,
    output logic signed [SAMPLE_BITS-1:0] m_last_raw_value,
    output logic signed [WEIGHT_BITS-1:0] m_weight_grams,
    output logic signed [SAMPLE_BITS-1:0] m_current_offset,
    output logic [COUNT_BITS-1:0]         m_reads_total,
    output logic [COUNT_BITS-1:0]         m_faults_total,
    output logic [TIME_BITS-1:0]          m_sample_age_ms
);

    localparam int NET_W = SAMPLE_BITS + 1;
    localparam int DW    = NET_W + 2 * FRAC_BITS + WEIGHT_BITS;
    localparam int HI_W  = DW - WEIGHT_BITS;

    seq_state_t state_reg, state_next;

    // configuration
    logic [TIMEOUT_BITS-1:0]        timeout_reg, stale_reg;
    logic signed [DIVISOR_BITS-1:0] divisor_reg;

    // latched transaction
    logic [2:0]                    in_kind_reg, in_kind_next;
    logic [TIME_BITS-1:0]          in_now_reg, in_now_next;
    logic signed [SAMPLE_BITS-1:0] in_raw_reg, in_raw_next;
    logic [TARE_CNT_BITS-1:0]      in_cnt_reg, in_cnt_next;
    logic signed [SAMPLE_BITS-1:0] in_off_reg, in_off_next;
    logic                          acc_reg, acc_next;

    // block state
    logic [2:0]                    status_reg, status_next;
    logic [1:0]                    tare_mode_reg, tare_mode_next;
    logic [TARE_CNT_BITS-1:0]      tare_target_reg, tare_target_next;
    logic [TARE_CNT_BITS-1:0]      tare_coll_reg, tare_coll_next;
    logic [TARE_SUM_BITS-1:0]      tare_sum_reg, tare_sum_next;
    logic signed [SAMPLE_BITS-1:0] offset_reg, offset_next;
    logic [TIME_BITS-1:0]          last_ready_reg, last_ready_next;
    logic [TIME_BITS-1:0]          next_check_reg, next_check_next;
    logic [COUNT_BITS-1:0]         reads_reg, reads_next;
    logic [COUNT_BITS-1:0]         faults_reg, faults_next;
    logic                          valid_rd_reg, valid_rd_next;
    logic signed [SAMPLE_BITS-1:0] latest_raw_reg, latest_raw_next;
    logic [WEIGHT_BITS-1:0]        weight_reg, weight_next;
    logic [TIME_BITS-1:0]          updated_reg, updated_next;
    logic                          neg_reg, neg_next;
    logic                          sat_reg, sat_next;

    // result register
    logic                          m_valid_reg, m_valid_next;
    logic [2:0]                    m_status_reg, m_status_next;
    logic [1:0]                    m_phase_reg, m_phase_next;
    logic                          m_acc_reg, m_acc_next;
    logic                          m_has_reg, m_has_next;
    logic signed [SAMPLE_BITS-1:0] m_raw_reg, m_raw_next;
    logic [WEIGHT_BITS-1:0]        m_weight_reg, m_weight_next;
    logic signed [SAMPLE_BITS-1:0] m_off_reg, m_off_next;
    logic [COUNT_BITS-1:0]         m_reads_reg, m_reads_next;
    logic [COUNT_BITS-1:0]         m_faults_reg, m_faults_next;
    logic [TIME_BITS-1:0]          m_age_reg, m_age_next;

    // divider hookup
    div_ctrl_t              div_ctrl;
    logic [DIV_RBITS-1:0]   div_rem_init;
    logic [DIV_QBITS-1:0]   div_dividend;
    logic [DIV_RBITS-1:0]   div_divisor;
    logic                   div_busy;
    logic [DIV_QBITS-1:0]   div_quo;

    // datapath helpers
    logic signed [TARE_SUM_BITS-1:0] raw_ext;
    logic [TARE_SUM_BITS-1:0]        sum_new;
    logic [TARE_SUM_BITS-1:0]        sum_mag;
    logic [TARE_CNT_BITS-1:0]        coll_new;
    logic [TARE_QBITS-1:0]           tare_q;
    logic [TARE_QBITS-1:0]           tare_q_signed;
    logic signed [NET_W-1:0]         net;
    logic [NET_W-1:0]                net_mag;
    logic [DW-1:0]                   dvd;
    logic [HI_W-1:0]                 dvd_hi;
    logic                            d_small;
    logic [DIVISOR_BITS-1:0]         d_mag;
    logic                            d_neg;
    logic [WEIGHT_BITS-1:0]          limit;
    logic [WEIGHT_BITS-1:0]          mag;
    logic [TIME_BITS-1:0]            since_ready;
    logic [TIME_BITS-1:0]            since_check;
    logic [TIME_BITS-1:0]            check_rearm;

    assign raw_ext  = TARE_SUM_BITS'(in_raw_reg);
    assign sum_new  = tare_sum_reg + raw_ext;
    assign sum_mag  = sum_new[TARE_SUM_BITS-1] ? -sum_new : sum_new;
    assign coll_new = tare_coll_reg + 1'b1;

    assign tare_q        = div_quo[TARE_QBITS-1:0];
    assign tare_q_signed = tare_sum_reg[TARE_SUM_BITS-1] ? -tare_q : tare_q;

    assign net     = NET_W'(in_raw_reg) - NET_W'(offset_reg);
    assign net_mag = net[NET_W-1] ? NET_W'(-net) : NET_W'(net);
    assign dvd     = DW'(net_mag) << (2 * FRAC_BITS);
    assign dvd_hi  = dvd[DW-1:WEIGHT_BITS];

    assign d_small = (divisor_reg > -DIVISOR_MIN_MAG) && (divisor_reg < DIVISOR_MIN_MAG);
    assign d_mag   = d_small ? (DIVISOR_BITS'(1) << FRAC_BITS)
                   : (divisor_reg[DIVISOR_BITS-1] ? DIVISOR_BITS'(-divisor_reg)
                                                  : DIVISOR_BITS'(divisor_reg));
    assign d_neg   = !d_small && divisor_reg[DIVISOR_BITS-1];

    assign limit = (WEIGHT_BITS'(1) << (WEIGHT_BITS - 1)) - WEIGHT_BITS'(!neg_reg);
    assign mag   = (sat_reg || (div_quo > limit)) ? limit : div_quo;

    assign since_ready = in_now_reg - last_ready_reg;
    assign since_check = in_now_reg - next_check_reg;
    assign check_rearm = in_now_reg + TIME_BITS'(timeout_reg);

    always_comb begin
        state_next       = state_reg;
        in_kind_next     = in_kind_reg;
        in_now_next      = in_now_reg;
        in_raw_next      = in_raw_reg;
        in_cnt_next      = in_cnt_reg;
        in_off_next      = in_off_reg;
        acc_next         = acc_reg;
        status_next      = status_reg;
        tare_mode_next   = tare_mode_reg;
        tare_target_next = tare_target_reg;
        tare_coll_next   = tare_coll_reg;
        tare_sum_next    = tare_sum_reg;
        offset_next      = offset_reg;
        last_ready_next  = last_ready_reg;
        next_check_next  = next_check_reg;
        reads_next       = reads_reg;
        faults_next      = faults_reg;
        valid_rd_next    = valid_rd_reg;
        latest_raw_next  = latest_raw_reg;
        weight_next      = weight_reg;
        updated_next     = updated_reg;
        neg_next         = neg_reg;
        sat_next         = sat_reg;
        m_valid_next     = m_valid_reg;
        m_status_next    = m_status_reg;
        m_phase_next     = m_phase_reg;
        m_acc_next       = m_acc_reg;
        m_has_next       = m_has_reg;
        m_raw_next       = m_raw_reg;
        m_weight_next    = m_weight_reg;
        m_off_next       = m_off_reg;
        m_reads_next     = m_reads_reg;
        m_faults_next    = m_faults_reg;
        m_age_next       = m_age_reg;
        div_ctrl         = '0;
        div_rem_init     = '0;
        div_dividend     = '0;
        div_divisor      = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            SEQ_IDLE: begin
                if (s_valid) begin
                    in_kind_next = s_kind;
                    in_now_next  = s_now_ms;
                    in_raw_next  = s_raw_sample;
                    in_cnt_next  = s_tare_count;
                    in_off_next  = s_offset_value;
                    state_next   = SEQ_EXEC;
                end
            end
            SEQ_EXEC: begin
                acc_next   = 1'b0;
                state_next = SEQ_REPORT;
                case (in_kind_reg)
                    KIND_BEGIN: begin
                        status_next     = STAT_INIT;
                        last_ready_next = in_now_reg;
                        next_check_next = check_rearm;
                    end
                    KIND_SAMPLE: begin
                        status_next     = STAT_HEALTHY;
                        last_ready_next = in_now_reg;
                        next_check_next = check_rearm;
                        reads_next      = reads_reg + 1'b1;
                        valid_rd_next   = 1'b1;
                        updated_next    = in_now_reg;
                        latest_raw_next = in_raw_reg;
                        state_next      = SEQ_W_PREP;
                        if (tare_mode_reg == TARE_COLLECT) begin
                            tare_sum_next  = sum_new;
                            tare_coll_next = coll_new;
                            if (coll_new >= tare_target_reg) begin
                                // average complete: new offset applies to this sample
                                div_ctrl.start = 1'b1;
                                div_ctrl.iters = DIV_CNT_W'(TARE_QBITS);
                                div_dividend   = DIV_QBITS'(sum_mag) << (DIV_QBITS - TARE_QBITS);
                                div_divisor    = DIV_RBITS'(tare_target_reg);
                                state_next     = SEQ_TARE_DIV;
                            end
                        end
                    end
                    KIND_POLL: begin
                        // wrap-safe due check
                        if (!since_check[TIME_BITS-1]) begin
                            next_check_next = check_rearm;
                            if (since_ready > TIME_BITS'(timeout_reg)) begin
                                status_next = STAT_FAULT;
                                faults_next = faults_reg + 1'b1;
                                if (tare_mode_reg == TARE_COLLECT) begin
                                    tare_mode_next = TARE_FAILED;
                                end
                            end
                        end
                    end
                    KIND_TARE: begin
                        if (in_cnt_reg != '0 && status_reg != STAT_FAULT) begin
                            tare_target_next = in_cnt_reg;
                            tare_coll_next   = '0;
                            tare_sum_next    = '0;
                            tare_mode_next   = TARE_COLLECT;
                            acc_next         = 1'b1;
                        end
                    end
                    KIND_OFFSET: begin
                        offset_next = in_off_reg;
                    end
                    default: begin
                    end
                endcase
            end
            SEQ_TARE_DIV: begin
                if (!div_busy) begin
                    state_next = SEQ_TARE_FIN;
                end
            end
            SEQ_TARE_FIN: begin
                offset_next    = tare_q_signed[SAMPLE_BITS-1:0];
                tare_mode_next = TARE_DONE;
                state_next     = SEQ_W_PREP;
            end
            SEQ_W_PREP: begin
                neg_next = net[NET_W-1] != d_neg;
                if (dvd_hi >= HI_W'(d_mag)) begin
                    // quotient needs more than the weight width
                    sat_next   = 1'b1;
                    state_next = SEQ_W_FIN;
                end else begin
                    sat_next       = 1'b0;
                    div_ctrl.start = 1'b1;
                    div_ctrl.iters = DIV_CNT_W'(DIV_QBITS);
                    div_rem_init   = dvd_hi[DIV_RBITS-1:0];
                    div_dividend   = dvd[WEIGHT_BITS-1:0];
                    div_divisor    = d_mag;
                    state_next     = SEQ_W_DIV;
                end
            end
            SEQ_W_DIV: begin
                if (!div_busy) begin
                    state_next = SEQ_W_FIN;
                end
            end
            SEQ_W_FIN: begin
                weight_next = neg_reg ? -mag : mag;
                state_next  = SEQ_REPORT;
            end
            SEQ_REPORT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = (status_reg == STAT_HEALTHY &&
                                     since_ready > TIME_BITS'(stale_reg)) ? STAT_STALE
                                                                          : status_reg;
                    m_phase_next  = tare_mode_reg;
                    m_acc_next    = acc_reg;
                    m_has_next    = valid_rd_reg;
                    m_raw_next    = latest_raw_reg;
                    m_weight_next = weight_reg;
                    m_off_next    = offset_reg;
                    m_reads_next  = reads_reg;
                    m_faults_next = faults_reg;
                    m_age_next    = in_now_reg - updated_reg;
                    state_next    = SEQ_IDLE;
                end
            end
            default: begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SEQ_IDLE;
            timeout_reg <= TIMEOUT_BITS'(1000);
            stale_reg   <= TIMEOUT_BITS'(500);
            divisor_reg <= 32'sd65536;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_TIMEOUT: timeout_reg <= cfg_wdata[TIMEOUT_BITS-1:0];
                    CFG_STALE:   stale_reg   <= cfg_wdata[TIMEOUT_BITS-1:0];
                    CFG_DIVISOR: divisor_reg <= cfg_wdata[DIVISOR_BITS-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg      <= STAT_OFFLINE;
            tare_mode_reg   <= TARE_IDLE;
            tare_target_reg <= '0;
            tare_coll_reg   <= '0;
            tare_sum_reg    <= '0;
            offset_reg      <= '0;
            last_ready_reg  <= '0;
            next_check_reg  <= '0;
            reads_reg       <= '0;
            faults_reg      <= '0;
            valid_rd_reg    <= 1'b0;
            latest_raw_reg  <= '0;
            weight_reg      <= '0;
            updated_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            status_reg      <= status_next;
            tare_mode_reg   <= tare_mode_next;
            tare_target_reg <= tare_target_next;
            tare_coll_reg   <= tare_coll_next;
            tare_sum_reg    <= tare_sum_next;
            offset_reg      <= offset_next;
            last_ready_reg  <= last_ready_next;
            next_check_reg  <= next_check_next;
            reads_reg       <= reads_next;
            faults_reg      <= faults_next;
            valid_rd_reg    <= valid_rd_next;
            latest_raw_reg  <= latest_raw_next;
            weight_reg      <= weight_next;
            updated_reg     <= updated_next;
            m_valid_reg     <= m_valid_next;
        end
        in_kind_reg   <= in_kind_next;
        in_now_reg    <= in_now_next;
        in_raw_reg    <= in_raw_next;
        in_cnt_reg    <= in_cnt_next;
        in_off_reg    <= in_off_next;
        acc_reg       <= acc_next;
        neg_reg       <= neg_next;
        sat_reg       <= sat_next;
        m_status_reg  <= m_status_next;
        m_phase_reg   <= m_phase_next;
        m_acc_reg     <= m_acc_next;
        m_has_reg     <= m_has_next;
        m_raw_reg     <= m_raw_next;
        m_weight_reg  <= m_weight_next;
        m_off_reg     <= m_off_next;
        m_reads_reg   <= m_reads_next;
        m_faults_reg  <= m_faults_next;
        m_age_reg     <= m_age_next;
    end

    lcts_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .init_rem (div_rem_init),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    assign s_ready          = (state_reg == SEQ_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_sensor_status  = m_status_reg;
    assign m_tare_phase     = m_phase_reg;
    assign m_tare_accepted  = m_acc_reg;
    assign m_has_reading    = m_has_reg;
    assign m_last_raw_value = m_raw_reg;
    assign m_weight_grams   = m_weight_reg;
    assign m_current_offset = m_off_reg;
    assign m_reads_total    = m_reads_reg;
    assign m_faults_total   = m_faults_reg;
    assign m_sample_age_ms  = m_age_reg;

    // a collecting tare always has a nonzero target to divide by
    assert property (@(posedge aclk) disable iff (!aresetn)
        tare_mode_reg == TARE_COLLECT |-> tare_target_reg != '0)
        else $error("collecting tare with zero target");

    // quotient is read only after the divider has finished
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SEQ_TARE_FIN || state_reg == SEQ_W_FIN) |-> !div_busy)
        else $error("divider result read while busy");

    // stale is only a reported view, never stored
    assert property (@(posedge aclk) disable iff (!aresetn)
        status_reg != STAT_STALE)
        else $error("stale stored as status");

    // a transaction is taken only while no divider pass runs
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> !div_busy)
        else $error("transaction accepted with divider busy");

endmodule
